[rtl/h263d_pkg.sv]
package h263d_pkg;

  // Header bit positions of the first RFC 2429 header byte
  localparam int PBit      = 2;
  localparam int VBit      = 1;
  localparam int PlenHiBit = 0;
  // PLEN low bits sit in the upper five bits of the second header byte
  localparam int PlenLoLsb = 3;
  localparam int PlenW     = 6;

  // Most results that one input item can produce
  localparam int RunDepth  = 2;
  localparam int RunCntW   = $clog2(RunDepth + 1);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXTRA,
    PH_VRC,
    PH_PAYLOAD
  } phase_t;

  // One input item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_end;
    logic       payload_format;
    logic       frame_mark;
  } item_t;

  // Parser state; only the P/V/PLEN-high bits of the first header byte are kept
  typedef struct packed {
    phase_t             phase;
    logic               v_flag;
    logic               plen_hi;
    logic [PlenW-1:0]   extra_left;
    logic               zeros_pending;
  } state_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       last_of_run;
  } result_t;

endpackage

[rtl/h263d_step.sv]
module h263d_step (
  input  h263d_pkg::item_t                 item,
  input  h263d_pkg::state_t                state,
  output h263d_pkg::state_t                state_next,
  output h263d_pkg::result_t               res0,
  output h263d_pkg::result_t               res1,
  output logic [h263d_pkg::RunCntW-1:0]    res_cnt
);

  logic [h263d_pkg::PlenW-1:0] plen;
  logic [h263d_pkg::PlenW-1:0] extra_dec;
  logic                        finish;

  assign plen = {state.plen_hi,
                 item.payload_byte[7:h263d_pkg::PlenLoLsb]};
  assign extra_dec = state.extra_left - 1'b1;

  always_comb begin
    state_next = state;
    res0       = '0;
    res1       = '0;
    res_cnt    = '0;
    finish     = 1'b0;

    // Header parse / payload pass
    case (state.phase)
      h263d_pkg::PH_SECOND: begin
        state_next.extra_left = plen;
        if (plen != '0) begin
          state_next.phase = h263d_pkg::PH_EXTRA;
        end else if (state.v_flag) begin
          state_next.phase = h263d_pkg::PH_VRC;
        end else begin
          finish = 1'b1;
        end
      end
      h263d_pkg::PH_EXTRA: begin
        state_next.extra_left = extra_dec;
        if (extra_dec == '0) begin
          if (state.v_flag) begin
            state_next.phase = h263d_pkg::PH_VRC;
          end else begin
            finish = 1'b1;
          end
        end
      end
      h263d_pkg::PH_VRC: begin
        finish = 1'b1;
      end
      h263d_pkg::PH_PAYLOAD: begin
        res0.out_byte   = item.payload_byte;
        res0.byte_valid = 1'b1;
        res_cnt         = h263d_pkg::RunCntW'(1);
      end
      default: begin
        // first byte of a packet; unused codes land here too
        if (!item.payload_format) begin
          res0.out_byte    = item.payload_byte;
          res0.byte_valid  = 1'b1;
          res_cnt          = h263d_pkg::RunCntW'(1);
          state_next.phase = h263d_pkg::PH_PAYLOAD;
        end else begin
          state_next.v_flag        = item.payload_byte[h263d_pkg::VBit];
          state_next.plen_hi       = item.payload_byte[h263d_pkg::PlenHiBit];
          state_next.zeros_pending = item.payload_byte[h263d_pkg::PBit];
          state_next.phase         = h263d_pkg::PH_SECOND;
        end
      end
    endcase

    // Header complete: start-code zeros if P was set
    if (finish) begin
      state_next.phase = h263d_pkg::PH_PAYLOAD;
      if (state.zeros_pending) begin
        res0.byte_valid          = 1'b1;
        res1.byte_valid          = 1'b1;
        res_cnt                  = h263d_pkg::RunCntW'(2);
        state_next.zeros_pending = 1'b0;
      end
    end

    // Packet end: marker result, frame end flag, back to first byte
    if (item.packet_end) begin
      if (item.frame_mark && res_cnt == '0) begin
        res_cnt = h263d_pkg::RunCntW'(1);
      end
      if (item.frame_mark) begin
        if (res_cnt == h263d_pkg::RunCntW'(2)) begin
          res1.frame_end = 1'b1;
        end else begin
          res0.frame_end = 1'b1;
        end
      end
      state_next.phase         = h263d_pkg::PH_FIRST;
      state_next.zeros_pending = 1'b0;
    end

    // Tag the last result of the run
    if (res_cnt == h263d_pkg::RunCntW'(2)) begin
      res1.last_of_run = 1'b1;
    end else if (res_cnt == h263d_pkg::RunCntW'(1)) begin
      res0.last_of_run = 1'b1;
    end
  end

endmodule

[rtl/h263_rtp_payload_depacketizer_core.sv]
// Channel  Dir  tdata             tuser                            tlast
// s_*      in   [7:0] payload_byte [0] payload_format [1] frame_mark  packet_end
// m_*      out  [7:0] out_byte     [0] byte_valid [1] last_of_run     frame_end
//
// Each input item is registered, parsed combinationally and its results (zero
// to two) are loaded into a two-entry run buffer that drains one result a cycle
// while m_tready is high. An item passes the input register, then the run buffer.
// One item per cycle is sustained while items make at most one result and the
// output is not stalled; a start-code run of two holds the input while the run
// buffer drains. rst is synchronous and clears the parser, the input register
// and the run buffer. Either side may stall at any time without loss.
module h263_rtp_payload_depacketizer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] payload_byte
  input  logic [1:0] s_tuser,   // [0] payload_format, [1] frame_mark
  input  logic       s_tlast,   // packet_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] byte_valid, [1] last_of_run
  output logic       m_tlast    // frame_end
);

  logic                              in_valid;
  h263d_pkg::item_t                  in_item;
  h263d_pkg::state_t                 state;
  h263d_pkg::state_t                 state_next;
  h263d_pkg::result_t                res0;
  h263d_pkg::result_t                res1;
  logic [h263d_pkg::RunCntW-1:0]     res_cnt;
  h263d_pkg::result_t                run0;
  h263d_pkg::result_t                run1;
  logic [h263d_pkg::RunCntW-1:0]     run_cnt;
  logic                              out_fire;
  logic                              run_free;
  logic                              commit;

  // Handshake control
  assign m_tvalid = (run_cnt != '0);
  assign out_fire = m_tvalid && m_tready;
  assign run_free = (run_cnt == '0) ||
                    (run_cnt == h263d_pkg::RunCntW'(1) && out_fire);
  assign commit   = in_valid && run_free;
  assign s_tready = !in_valid || commit;

  assign m_tdata  = run0.out_byte;
  assign m_tuser  = {run0.last_of_run, run0.byte_valid};
  assign m_tlast  = run0.frame_end;

  h263d_step u_step (
    .item       (in_item),
    .state      (state),
    .state_next (state_next),
    .res0       (res0),
    .res1       (res1),
    .res_cnt    (res_cnt)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      run_cnt  <= '0;
      state    <= '{phase: h263d_pkg::PH_FIRST, default: '0};
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (commit) begin
        state   <= state_next;
        run_cnt <= res_cnt;
      end else if (out_fire) begin
        run_cnt <= run_cnt - 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.payload_byte   <= s_tdata;
      in_item.packet_end     <= s_tlast;
      in_item.payload_format <= s_tuser[0];
      in_item.frame_mark     <= s_tuser[1];
    end
    if (commit) begin
      run0 <= res0;
      run1 <= res1;
    end else if (out_fire) begin
      run0 <= run1;
    end
  end

endmodule
